// ===== rtl/rth_pkg.sv =====
package rth_pkg;

	localparam int unsigned NumCells = 16;
	localparam logic [14:0] HueFull = 15'd23040;
	localparam logic [12:0] HueSixth = 13'd3840;

	typedef struct packed {
		logic [7:0]  rem;
		logic [15:0] nq;
		logic [7:0]  dv;
	} lane_t;

	typedef struct packed {
		lane_t       hue;
		lane_t       sat;
		logic [15:0] lig;
	} cell_t;

endpackage

// ===== rtl/rth_if.sv =====
interface rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

interface hsl_if;
	logic        valid;
	logic        ready;
	logic [14:0] hue;
	logic [15:0] saturation;
	logic [15:0] lightness;
	modport source (output valid, hue, saturation, lightness, input ready);
	modport sink (input valid, hue, saturation, lightness, output ready);
endinterface

// ===== rtl/rgb_to_hsl_top.sv =====
// rgb to hsl converter: one pixel a clock unless the output stalls; a row
// of 16 divider cells produces one quotient bit each for hue and saturation
// in parallel; lightness rides along. each cell stalls only when it is full
// and its neighbor cannot take, so the input keeps accepting while a result
// waits at the output until the row is full.
module rgb_to_hsl_top
	import rth_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	rgb_if.sink   pix,
	hsl_if.source hsl
);

	cell_t chain_d [NumCells+1];
	logic  chain_v [NumCells+1];
	logic  chain_r [NumCells+1];

	rth_front u_front (
		.red   (pix.red),
		.green (pix.green),
		.blue  (pix.blue),
		.seed  (chain_d[0])
	);

	assign chain_v[0] = pix.valid;
	assign pix.ready = chain_r[0];

	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		rth_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_v[i]),
			.in_ready  (chain_r[i]),
			.in_data   (chain_d[i]),
			.out_valid (chain_v[i+1]),
			.out_ready (chain_r[i+1]),
			.out_data  (chain_d[i+1])
		);
	end

	assign chain_r[NumCells] = hsl.ready;
	assign hsl.valid = chain_v[NumCells];
	assign hsl.hue = chain_d[NumCells].hue.nq[14:0];
	assign hsl.saturation = chain_d[NumCells].sat.nq;
	assign hsl.lightness = chain_d[NumCells].lig;

`ifndef NO_ASSERTIONS
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsl.valid |-> hsl.hue < HueFull) else $error("hue out of range");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		chain_v[1] |-> (chain_d[1].hue.dv != 8'd0 && chain_d[1].sat.dv != 8'd0))
		else $error("zero divisor in chain");
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready) |=> chain_v[1]) else $error("transaction lost");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chain_v[1] |-> chain_d[1].hue.rem < chain_d[1].hue.dv)
		else $error("remainder exceeds divisor");
`endif

endmodule

// ===== rtl/rth_front.sv =====
module rth_front
	import rth_pkg::*;
(
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output cell_t      seed
);

	logic [7:0] mx, mn, d, t;
	logic [8:0] s;
	logic signed [8:0] x;
	logic signed [24:0] base, nh;
	logic [23:0] ns;
	logic [16:0] s257;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		d = mx - mn;
		s = {1'b0, mx} + {1'b0, mn};
		if (mx == red) begin
			x = $signed({1'b0, green}) - $signed({1'b0, blue});
			base = (x < 0) ? 25'(d) * 25'(HueFull) : 25'sd0;
		end else if (mx == green) begin
			x = $signed({1'b0, blue}) - $signed({1'b0, red});
			base = 25'(d) * 25'(2 * HueSixth);
		end else begin
			x = $signed({1'b0, red}) - $signed({1'b0, green});
			base = 25'(d) * 25'(4 * HueSixth);
		end
		nh = base + 25'(x) * $signed({12'd0, HueSixth});
		t = (s <= 9'd255) ? s[7:0] : 8'(9'd510 - s);
		ns = {d, 16'd0} - 24'(d);
		s257 = {s, 8'd0} + 17'(s);
		// grey: numerator 0 over divisor 1 gives a zero quotient
		if (d == 8'd0) begin
			seed.hue = '{rem: 8'd0, nq: 16'd0, dv: 8'd1};
			seed.sat = '{rem: 8'd0, nq: 16'd0, dv: 8'd1};
		end else begin
			seed.hue = '{rem: nh[23:16], nq: nh[15:0], dv: d};
			seed.sat = '{rem: ns[23:16], nq: ns[15:0], dv: t};
		end
		seed.lig = s257[16:1];
	end

endmodule

// ===== rtl/rth_cell.sv =====
module rth_cell
	import rth_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  cell_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output cell_t out_data
);

	cell_t nxt;
	cell_t data_q;
	logic  valid_q;

	function automatic lane_t step(lane_t l);
		logic [8:0] tr;
		logic [8:0] df;
		logic       ge;
		lane_t      o;
		tr = {l.rem, l.nq[15]};
		df = tr - {1'b0, l.dv};
		ge = tr >= {1'b0, l.dv};
		o.rem = ge ? df[7:0] : tr[7:0];
		o.nq = {l.nq[14:0], ge};
		o.dv = l.dv;
		return o;
	endfunction

	always_comb begin
		nxt.hue = step(in_data.hue);
		nxt.sat = step(in_data.sat);
		nxt.lig = in_data.lig;
	end

	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

endmodule
